@@ design/gradient_bar_pixel_color_unit_assert.svh @@
// Assertion macros for the gradient bar pixel colour unit.
// Included by the top-level RTL file, which carries concurrent checks; no other dependencies.
`ifndef GRADIENT_BAR_PIXEL_COLOR_UNIT_ASSERT_SVH
`define GRADIENT_BAR_PIXEL_COLOR_UNIT_ASSERT_SVH
`ifndef SYNTH
// Checked property with the asynchronous reset masking it.
`define GBPC_ASSERT(label, clock, rstn, prop) \
	label: assert property (@(posedge clock) disable iff (!rstn) prop) \
		else $error("gbpc assertion failed");
// Checked property that also holds through reset.
`define GBPC_ASSERT_ALWAYS(label, clock, prop) \
	label: assert property (@(posedge clock) prop) \
		else $error("gbpc assertion failed");
`else
`define GBPC_ASSERT(label, clock, rstn, prop)
`define GBPC_ASSERT_ALWAYS(label, clock, prop)
`endif
`endif

@@ design/gbpc_pkg.sv @@
// Shared widths, register codes and types of the gradient bar pixel colour unit.
// Depends on nothing; imported by gbpc_div2 and the top level.
package gbpc_pkg;

	localparam int LEN_W   = 13;
	localparam int LVL_W   = 8;
	localparam int COL_W   = 13;
	localparam int HALF_W  = 12;
	localparam int COLOR_W = 24;
	localparam int CH_W    = 8;
	localparam int N_CH    = 3;
	localparam int PROD_W  = 21;
	localparam int NEED_W  = 22;
	localparam int DIV_W   = 21;
	localparam int Q_W     = 8;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	localparam int LEVEL_FULL = 255;

	localparam logic [1:0] REG_BAR_LENGTH = 2'd0;
	localparam logic [1:0] REG_COLOR_MIN  = 2'd1;
	localparam logic [1:0] REG_COLOR_MED  = 2'd2;
	localparam logic [1:0] REG_COLOR_MAX  = 2'd3;

	// Partial remainder and quotient of one channel's restoring division.
	typedef struct packed {
		logic [DIV_W-1:0] rem;
		logic [Q_W-1:0]   quo;
	} gbpc_div_t;

	typedef logic [N_CH-1:0][CH_W-1:0] gbpc_rgb_t;

endpackage

@@ design/gbpc_div2.sv @@
// Two restoring division steps for one colour channel, retiring two quotient bits.
// Depends on gbpc_pkg for the division state type.
module gbpc_div2 import gbpc_pkg::*; (
	input  gbpc_div_t        d_in,
	input  logic [DIV_W-1:0] dvs,
	output gbpc_div_t        d_out
);

	logic [DIV_W-1:0] dvs_lo;
	logic [DIV_W-1:0] rem_mid;
	logic             ge_hi;
	logic             ge_lo;

	assign dvs_lo = dvs >> 1;

	always_comb begin
		ge_hi   = d_in.rem >= dvs;
		rem_mid = ge_hi ? d_in.rem - dvs : d_in.rem;
		ge_lo   = rem_mid >= dvs_lo;
		d_out.rem = ge_lo ? rem_mid - dvs_lo : rem_mid;
		d_out.quo = {d_in.quo[Q_W-3:0], ge_hi, ge_lo};
	end

endmodule

@@ design/gradient_bar_pixel_color_unit.sv @@
// Gradient bar pixel colour unit: takes one pixel column and meter level per transfer
// and returns whether the column is filled and its three-stop RGB888 colour.
// Depends on gbpc_pkg, gbpc_div2 and gradient_bar_pixel_color_unit_assert.svh.
`include "gradient_bar_pixel_color_unit_assert.svh"

// The unit accepts one item transfer in every clock cycle while no held result
// stalls it, so a raster scan can stream one pixel per clock. The seven
// register stages are: operand set-up (fill product, segment choice and offset),
// fill compare and per-channel offset times colour difference, four stages of
// radix-4 restoring division by the half length (two quotient bits each), and a
// final stage that applies the sign, adds the segment's start colour and blanks
// unfilled pixels. The whole pipeline advances together whenever the output
// register is empty or its result transfer completes, so a held result stalls
// every stage in place and nothing is lost or repeated. The filled length is
// never formed as a quotient: a column is inside it exactly when 255 times
// (column + 1) does not exceed bar_length times level. Registers are written
// over the APB port at byte addresses 0 (bar_length), 4 (color_min), 8
// (color_med) and 12 (color_max), and should only be changed while no items
// are in flight.
module gradient_bar_pixel_color_unit import gbpc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// Configuration port.
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	// Item channel.
	input  logic               item_valid,
	output logic               item_ready,
	input  logic [COL_W-1:0]   column,
	input  logic [LVL_W-1:0]   level,
	// Result channel.
	output logic               result_valid,
	input  logic               result_ready,
	output logic               filled,
	output logic [COLOR_W-1:0] pixel_color
);

	// Configuration registers.
	logic [LEN_W-1:0]   bar_length_q;
	logic [COLOR_W-1:0] color_min_q;
	logic [COLOR_W-1:0] color_med_q;
	logic [COLOR_W-1:0] color_max_q;
	logic               cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bar_length_q <= '0;
			color_min_q  <= '0;
			color_med_q  <= '0;
			color_max_q  <= '0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_BAR_LENGTH: bar_length_q <= pwdata[LEN_W-1:0];
				REG_COLOR_MIN:  color_min_q  <= pwdata[COLOR_W-1:0];
				REG_COLOR_MED:  color_med_q  <= pwdata[COLOR_W-1:0];
				REG_COLOR_MAX:  color_max_q  <= pwdata[COLOR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_BAR_LENGTH: prdata = DATA_W'(bar_length_q);
			REG_COLOR_MIN:  prdata = DATA_W'(color_min_q);
			REG_COLOR_MED:  prdata = DATA_W'(color_med_q);
			REG_COLOR_MAX:  prdata = DATA_W'(color_max_q);
			default:        prdata = '0;
		endcase
	end

	// Global pipeline advance: every stage moves when the output register can take
	// a new value.
	logic advance;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;

	assign advance    = !valid_s7 || result_ready;
	assign item_ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= item_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	// Stage 1: fill product, the threshold it must reach, segment and offset.
	logic [HALF_W-1:0] half_c;
	logic [COL_W:0]    col_inc_c;
	logic              seg2_c;
	logic [COL_W-1:0]  offset_c;

	logic [PROD_W-1:0] prod_s1;
	logic [NEED_W-1:0] need_s1;
	logic [COL_W-1:0]  offset_s1;
	logic [HALF_W-1:0] half_s1;
	gbpc_rgb_t         a_s1, b_s1;

	always_comb begin
		half_c    = bar_length_q[LEN_W-1:1];
		col_inc_c = {1'b0, column} + (COL_W+1)'(1);
		seg2_c    = column >= COL_W'(half_c);
		offset_c  = seg2_c ? column - COL_W'(half_c) : column;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			prod_s1   <= PROD_W'(bar_length_q) * PROD_W'(level);
			need_s1   <= NEED_W'(col_inc_c) * NEED_W'(LEVEL_FULL);
			offset_s1 <= offset_c;
			half_s1   <= half_c;
			a_s1      <= seg2_c ? color_med_q : color_min_q;
			b_s1      <= seg2_c ? color_max_q : color_med_q;
		end
	end

	// Stage 2: fill decision and the magnitude of offset times colour difference.
	logic              filled_s2, zero_half_s2;
	logic [DIV_W-1:0]  dvs_s2;
	gbpc_rgb_t         a_s2;
	logic [N_CH-1:0]   neg_s2;
	gbpc_div_t         div_s2 [N_CH];

	always_ff @(posedge clk) begin
		if (advance) begin
			filled_s2    <= NEED_W'(prod_s1) >= need_s1;
			zero_half_s2 <= half_s1 == '0;
			dvs_s2       <= DIV_W'({half_s1, 7'b0});
			a_s2         <= a_s1;
		end
	end

	for (genvar ch = 0; ch < N_CH; ch++) begin : g_diff
		logic            neg_c;
		logic [CH_W-1:0] mag_c;

		always_comb begin
			neg_c = b_s1[ch] < a_s1[ch];
			mag_c = neg_c ? a_s1[ch] - b_s1[ch] : b_s1[ch] - a_s1[ch];
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				neg_s2[ch]     <= neg_c;
				div_s2[ch].rem <= DIV_W'(offset_s1) * DIV_W'(mag_c);
				div_s2[ch].quo <= '0;
			end
		end
	end

	// Stages 3 to 6: restoring division by the half length, two bits per stage.
	logic             filled_s3, filled_s4, filled_s5, filled_s6;
	logic             zero_half_s3, zero_half_s4, zero_half_s5, zero_half_s6;
	logic [DIV_W-1:0] dvs_s3, dvs_s4, dvs_s5;
	gbpc_rgb_t        a_s3, a_s4, a_s5, a_s6;
	logic [N_CH-1:0]  neg_s3, neg_s4, neg_s5, neg_s6;
	gbpc_div_t        div_s3 [N_CH];
	gbpc_div_t        div_s4 [N_CH];
	gbpc_div_t        div_s5 [N_CH];
	gbpc_div_t        div_s6 [N_CH];

	always_ff @(posedge clk) begin
		if (advance) begin
			filled_s3    <= filled_s2;
			filled_s4    <= filled_s3;
			filled_s5    <= filled_s4;
			filled_s6    <= filled_s5;
			zero_half_s3 <= zero_half_s2;
			zero_half_s4 <= zero_half_s3;
			zero_half_s5 <= zero_half_s4;
			zero_half_s6 <= zero_half_s5;
			dvs_s3       <= dvs_s2 >> 2;
			dvs_s4       <= dvs_s3 >> 2;
			dvs_s5       <= dvs_s4 >> 2;
			a_s3         <= a_s2;
			a_s4         <= a_s3;
			a_s5         <= a_s4;
			a_s6         <= a_s5;
			neg_s3       <= neg_s2;
			neg_s4       <= neg_s3;
			neg_s5       <= neg_s4;
			neg_s6       <= neg_s5;
		end
	end

	for (genvar ch = 0; ch < N_CH; ch++) begin : g_div
		gbpc_div_t nxt3, nxt4, nxt5, nxt6;

		gbpc_div2 u_div3 (.d_in(div_s2[ch]), .dvs(dvs_s2), .d_out(nxt3));
		gbpc_div2 u_div4 (.d_in(div_s3[ch]), .dvs(dvs_s3), .d_out(nxt4));
		gbpc_div2 u_div5 (.d_in(div_s4[ch]), .dvs(dvs_s4), .d_out(nxt5));
		gbpc_div2 u_div6 (.d_in(div_s5[ch]), .dvs(dvs_s5), .d_out(nxt6));

		always_ff @(posedge clk) begin
			if (advance) begin
				div_s3[ch] <= nxt3;
				div_s4[ch] <= nxt4;
				div_s5[ch] <= nxt5;
				div_s6[ch] <= nxt6;
			end
		end
	end

	// Stage 7: signed step onto the start colour, blanked when unfilled. A zero
	// half length contributes no step, leaving the segment's start colour.
	logic      filled_s7;
	gbpc_rgb_t color_s7;
	gbpc_rgb_t color_c;

	for (genvar ch = 0; ch < N_CH; ch++) begin : g_out
		logic [Q_W-1:0] step_c;

		always_comb begin
			step_c = zero_half_s6 ? '0 : div_s6[ch].quo;
			color_c[ch] = neg_s6[ch] ? a_s6[ch] - step_c : a_s6[ch] + step_c;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			filled_s7 <= filled_s6;
			color_s7  <= filled_s6 ? color_c : '0;
		end
	end

	assign result_valid = valid_s7;
	assign filled       = filled_s7;
	assign pixel_color  = COLOR_W'(color_s7);

	// Checks.
	`GBPC_ASSERT(a_unfilled_black, clk, arst_n, (result_valid && !filled) |-> (pixel_color == '0))
	`GBPC_ASSERT(a_result_held, clk, arst_n, (result_valid && !result_ready) |=> (result_valid && $stable(filled) && $stable(pixel_color)))
	`GBPC_ASSERT_ALWAYS(a_ready_tracks, clk, item_ready == (!result_valid || result_ready))
	`GBPC_ASSERT(a_bar_length_wr, clk, arst_n, (cfg_wr && paddr[3:2] == REG_BAR_LENGTH) |=> (bar_length_q == $past(pwdata[LEN_W-1:0])))

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the gradient bar pixel colour unit: streams pixel
// columns and levels through the block and checks every result against its own model.
// Depends on gbpc_pkg and gradient_bar_pixel_color_unit; reads nothing from disk.

import gbpc_pkg::*;

// One predicted result: the fill flag and the colour that goes with it.
typedef struct {
	logic               filled;
	logic [COLOR_W-1:0] color;
} bar_pixel_t;

// Keeps a shadow copy of the four registers, predicts the result of each accepted
// item and compares the results, in order, with those predictions.
class bar_pixel_ledger;
	bar_pixel_t         pixels_due[$];
	logic [LEN_W-1:0]   bar_length;
	logic [COLOR_W-1:0] color_min;
	logic [COLOR_W-1:0] color_med;
	logic [COLOR_W-1:0] color_max;
	int                 mismatches;

	function new();
		bar_length = '0;
		color_min  = '0;
		color_med  = '0;
		color_max  = '0;
		mismatches = 0;
	endfunction

	function void write_reg(logic [1:0] idx, logic [DATA_W-1:0] value);
		case (idx)
			REG_BAR_LENGTH: bar_length = value[LEN_W-1:0];
			REG_COLOR_MIN:  color_min  = value[COLOR_W-1:0];
			REG_COLOR_MED:  color_med  = value[COLOR_W-1:0];
			REG_COLOR_MAX:  color_max  = value[COLOR_W-1:0];
			default: ;
		endcase
	endfunction

	function logic [DATA_W-1:0] reg_value(logic [1:0] idx);
		logic [DATA_W-1:0] value;
		value = '0;
		case (idx)
			REG_BAR_LENGTH: value[LEN_W-1:0]   = bar_length;
			REG_COLOR_MIN:  value[COLOR_W-1:0] = color_min;
			REG_COLOR_MED:  value[COLOR_W-1:0] = color_med;
			REG_COLOR_MAX:  value[COLOR_W-1:0] = color_max;
			default: ;
		endcase
		return value;
	endfunction

	// Linear blend of each channel; the signed division truncates toward zero.
	function logic [COLOR_W-1:0] blend(int offset, int span, logic [COLOR_W-1:0] c0,
			logic [COLOR_W-1:0] c1);
		logic [COLOR_W-1:0] rgb;
		int a;
		int b;
		int delta;
		if (span == 0)
			return c0;
		rgb = '0;
		for (int ch = 0; ch < N_CH; ch++) begin
			a = c0[ch*CH_W +: CH_W];
			b = c1[ch*CH_W +: CH_W];
			delta = (offset * (b - a)) / span;
			rgb[ch*CH_W +: CH_W] = CH_W'(a + delta);
		end
		return rgb;
	endfunction

	function void note_item(logic [COL_W-1:0] col, logic [LVL_W-1:0] lvl);
		int len;
		int lv;
		int cv;
		int fill_len;
		int span;
		bar_pixel_t px;
		len = bar_length;
		lv = lvl;
		cv = col;
		fill_len = (len * lv) / LEVEL_FULL;
		span = len / 2;
		px.filled = (cv < fill_len);
		px.color = '0;
		if (px.filled) begin
			if (cv < span)
				px.color = blend(cv, span, color_min, color_med);
			else
				px.color = blend(cv - span, span, color_med, color_max);
		end
		pixels_due.push_back(px);
	endfunction

	function void flag(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch, expected %h, got %h", $realtime, what, want, got);
		end
	endfunction

	function void check_result(logic f, logic [COLOR_W-1:0] c);
		bar_pixel_t px;
		if (pixels_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: result with nothing outstanding, filled %b colour %h",
					$realtime, f, c);
			return;
		end
		px = pixels_due.pop_front();
		flag("filled", DATA_W'(px.filled), DATA_W'(f));
		flag("pixel_color", DATA_W'(px.color), DATA_W'(c));
	endfunction
endclass

module tb;

	// Length of the block's pipeline from an item transfer to its result.
	localparam int LATENCY     = 7;
	// Cycles without any transfer before the run is declared hung. The worst
	// stalls come from the sender or the receiver idling in most cycles, and
	// this limit leaves a wide margin over them.
	localparam int STALL_LIMIT = 5000;
	localparam int ITEMS_PER_SETUP = 50;
	localparam logic [COL_W-1:0] COL_TOP = '1;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [ADDR_W-1:0]  paddr = '0;
	logic [DATA_W-1:0]  pwdata = '0;
	logic [DATA_W-1:0]  prdata;
	logic               pready;
	logic               item_valid = 1'b0;
	logic               item_ready;
	logic [COL_W-1:0]   column = '0;
	logic [LVL_W-1:0]   level = '0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	logic               filled;
	logic [COLOR_W-1:0] pixel_color;

	// Percentage of cycles in which the sender and the receiver hold back.
	int src_idle  = 22;
	int sink_idle = 88;
	int stall_cycles = 0;

	bar_pixel_ledger ledger = new();

	gradient_bar_pixel_color_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.column      (column),
		.level       (level),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.filled      (filled),
		.pixel_color (pixel_color)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// The receiver decides at each falling edge whether it takes a result in the
	// coming cycle, so its stalls land on every stage of the pipeline.
	always @(negedge clk) begin
		result_ready <= ($urandom_range(0, 99) >= sink_idle);
	end

	// Results are sampled at the rising edge. The same block watches for a hang:
	// any item, result or register transfer restarts the count.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready)
				ledger.check_result(filled, pixel_color);
			if ((item_valid && item_ready) || (result_valid && result_ready) ||
					(psel && penable))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// A register write: setup cycle, then the access cycle in which the register
	// takes the value at the rising edge.
	task automatic apb_write(logic [1:0] idx, logic [DATA_W-1:0] value);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		ledger.write_reg(idx, value);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// A register read; the data is taken at the edge that completes the access.
	task automatic apb_readback(logic [1:0] idx);
		logic [DATA_W-1:0] mask;
		mask = (idx == REG_BAR_LENGTH) ? DATA_W'((1 << LEN_W) - 1) :
			DATA_W'((1 << COLOR_W) - 1);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = {idx, 2'b00};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		ledger.flag("register readback", ledger.reg_value(idx), prdata & mask);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	// New bar geometry and colours. The pipeline is drained first, and since
	// every item gives a result an empty queue means nothing is in flight; the
	// extra wait only keeps the write clear of the last result transfer.
	task automatic load_setup(logic [LEN_W-1:0] len, logic [COLOR_W-1:0] cmin,
			logic [COLOR_W-1:0] cmed, logic [COLOR_W-1:0] cmax);
		item_valid = 1'b0;
		while (ledger.pixels_due.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(negedge clk);
		apb_write(REG_BAR_LENGTH, DATA_W'(len));
		apb_write(REG_COLOR_MIN, DATA_W'(cmin));
		apb_write(REG_COLOR_MED, DATA_W'(cmed));
		apb_write(REG_COLOR_MAX, DATA_W'(cmax));
		apb_readback(REG_BAR_LENGTH);
		apb_readback(REG_COLOR_MIN);
		apb_readback(REG_COLOR_MED);
		apb_readback(REG_COLOR_MAX);
	endtask

	// One item transfer. Called at a falling edge and returns at one; valid is
	// left high so that back-to-back items run at full rate, and is only
	// dropped when the sender decides to idle.
	task automatic send_pixel(logic [COL_W-1:0] col, logic [LVL_W-1:0] lvl);
		while ($urandom_range(0, 99) < src_idle) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		item_valid = 1'b1;
		column = col;
		level = lvl;
		do @(posedge clk); while (!item_ready);
		ledger.note_item(col, lvl);
		@(negedge clk);
	endtask

	// Columns mostly fall inside the bar, with a share around the midpoint where
	// the segment changes and a share anywhere in the column range.
	function automatic logic [COL_W-1:0] pick_column(int len);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 20)
			return COL_W'($urandom_range(0, COL_TOP));
		if (roll < 35)
			return COL_W'(len / 2 - 1 + $urandom_range(0, 2));
		return COL_W'($urandom_range(0, len));
	endfunction

	function automatic logic [LVL_W-1:0] pick_level();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 15)
			return LVL_W'(LEVEL_FULL);
		if (roll < 20)
			return '0;
		return LVL_W'($urandom_range(0, LEVEL_FULL));
	endfunction

	initial begin
		logic [LEN_W-1:0]   len;
		logic [COLOR_W-1:0] cmin;
		logic [COLOR_W-1:0] cmed;
		logic [COLOR_W-1:0] cmax;

		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Straight after reset the bar has zero length, so nothing is filled.
		send_pixel('0, LVL_W'(LEVEL_FULL));
		send_pixel(COL_TOP, LVL_W'(LEVEL_FULL));

		// A one-pixel bar has a half length of zero. Its only column sits in
		// the second segment and must come back as the midpoint colour.
		load_setup(LEN_W'(1), 24'h123456, 24'ha5c3e1, 24'hfedcba);
		send_pixel('0, LVL_W'(LEVEL_FULL));
		send_pixel('0, LVL_W'(LEVEL_FULL - 1));
		send_pixel(COL_W'(1), LVL_W'(LEVEL_FULL));

		// The longest bar, with channels that both rise and fall in each
		// segment, probed at the ends, either side of the midpoint, at the
		// edge of the filled length and with empty and full levels.
		load_setup('1, 24'hff00ff, 24'h00ff00, 24'hff0000);
		send_pixel('0, LVL_W'(LEVEL_FULL));
		send_pixel(COL_W'(1), LVL_W'(LEVEL_FULL));
		send_pixel(COL_W'(4094), LVL_W'(LEVEL_FULL));
		send_pixel(COL_W'(4095), LVL_W'(LEVEL_FULL));
		send_pixel(COL_W'(4096), LVL_W'(LEVEL_FULL));
		send_pixel(COL_TOP - 1, LVL_W'(LEVEL_FULL));
		send_pixel(COL_TOP, LVL_W'(LEVEL_FULL));
		send_pixel('0, '0);
		send_pixel(COL_TOP, '0);
		send_pixel(COL_W'(31), LVL_W'(1));
		send_pixel(COL_W'(32), LVL_W'(1));
		send_pixel(COL_TOP - 1, LVL_W'(LEVEL_FULL - 1));
		send_pixel(COL_W'(5000), LVL_W'(128));

		// Two pixels: the first segment starts at the minimum colour and the
		// second at the midpoint colour, each with a half length of one.
		load_setup(LEN_W'(2), 24'h00ff80, 24'hff0080, 24'h808080);
		send_pixel('0, LVL_W'(LEVEL_FULL));
		send_pixel(COL_W'(1), LVL_W'(LEVEL_FULL));

		// Random part in three stretches of flow control: a busy receiver,
		// then a slow sender, then both at full rate. Each stretch runs
		// through five bar set-ups, from the longest bar to tiny ones.
		for (int stretch = 0; stretch < 3; stretch++) begin
			case (stretch)
				0: begin
					src_idle = 22;
					sink_idle = 88;
				end
				1: begin
					src_idle = 88;
					sink_idle = 22;
				end
				default: begin
					src_idle = 0;
					sink_idle = 0;
				end
			endcase
			for (int setup = 0; setup < 5; setup++) begin
				cmin = COLOR_W'($urandom());
				cmed = COLOR_W'($urandom());
				cmax = COLOR_W'($urandom());
				case (setup)
					0: begin
						len = '1;
						// Full swings between black and white on the first two
						// stretches put every channel at its extremes.
						if (stretch == 0) begin
							cmin = '0;
							cmed = '1;
							cmax = '0;
						end else if (stretch == 1) begin
							cmin = '1;
							cmed = '0;
							cmax = '1;
						end
					end
					1: len = LEN_W'($urandom_range(2, 40));
					2: len = LEN_W'($urandom_range(0, 3));
					3: len = LEN_W'($urandom_range(0, COL_TOP));
					default: len = LEN_W'($urandom_range(4, 300));
				endcase
				load_setup(len, cmin, cmed, cmax);
				for (int n = 0; n < ITEMS_PER_SETUP; n++)
					send_pixel(pick_column(len), pick_level());
			end
		end

		item_valid = 1'b0;
		while (ledger.pixels_due.size() != 0)
			@(posedge clk);
		repeat (4 * LATENCY) @(posedge clk);
		if (ledger.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
